// File: sv/bezier_fit_newton_inverse_core_defines.svh
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BEZIER_FIT_NEWTON_INVERSE_CORE_DEFINES_SVH
`define BEZIER_FIT_NEWTON_INVERSE_CORE_DEFINES_SVH

// Same-cycle implication
`define BFN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bfn_pkg.sv
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse: package
// Fixed-point widths, control point tables, sequencer states and codes.
// ----------------------------------------------------------------------------
package bfn_pkg;

  localparam int CurvePoints = 9;
  localparam int FracBits    = 31;
  localparam int ChiFrac     = 28;
  localparam int TabFrac     = 40;

  // Signed width of curve points and lerp results
  localparam int PW = 36;
  // Divider remainder / divisor width
  localparam int DW = 40;
  // Divider quotient width (Newton step saturates at 2.0 in Q2.31)
  localparam int QW = 33;

  typedef logic signed [PW-1:0] pt_t;
  typedef pt_t pts_t [CurvePoints];

  // Frequency control point, rounded from 40 fraction bits down to FracBits
  function automatic pt_t qf(input longint unsigned x);
    longint unsigned raw;
    raw = (x * (64'd1 << TabFrac) + 64'd50000) / 64'd100000;
    raw = (raw + (64'd1 << (TabFrac - FracBits - 1))) >> (TabFrac - FracBits);
    return pt_t'(raw);
  endfunction

  // Chi control point, Q8.28
  function automatic pt_t qc(input longint unsigned x);
    longint unsigned raw;
    raw = (x * (64'd1 << ChiFrac) + 64'd5000) / 64'd10000;
    return pt_t'(raw);
  endfunction

  localparam pts_t FreqPts = '{qf(0), qf(16204), qf(36886), qf(27954), qf(47948),
                               qf(36266), qf(50724), qf(63124), qf(80111)};
  localparam pts_t ChiPts  = '{qc(10000), qc(10000), qc(21021), qc(46026), qc(46111),
                               qc(69099), qc(25099), qc(16516), qc(13674)};

  // Configuration register indexes
  localparam logic [1:0] CfgTol   = 2'd0;
  localparam logic [1:0] CfgMinIt = 2'd1;
  localparam logic [1:0] CfgMaxIt = 2'd2;

  // Status codes
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatRange  = 2'd1;
  localparam logic [1:0] StatNoConv = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StNormDiv,
    StNormChk,
    StEval,
    StDivSetup,
    StDivRun,
    StUpdate,
    StScale,
    StSat,
    StDone
  } state_e;

  // Divider request and status
  typedef struct packed {
    logic       start;
    logic       q_init;
    logic [5:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/bfn_div.sv
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse: restoring divider
// One quotient bit per cycle from a remainder below the divisor.
// ----------------------------------------------------------------------------
module bfn_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bfn_pkg::div_req_t        req_i,
  input  logic [bfn_pkg::DW-1:0]   num_i,
  input  logic [bfn_pkg::DW-1:0]   den_i,
  output bfn_pkg::div_stat_t       stat_o,
  output logic [bfn_pkg::QW-1:0]   quo_o
);
  import bfn_pkg::*;

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] quo_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;

  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  // One shift-subtract step
  assign rem_sh  = {rem_q, 1'b0};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= QW'(req_i.q_init);
    end else if (busy_q) begin
      rem_q <= rem_sub[DW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;

endmodule

// File: sv/bezier_fit_newton_inverse_core.sv
// Newton steps skip the divide for a zero-slope or saturated step; a frequency past
// the curve end, a zero rate or freq >= rate skips the search.
// One item at a time. Curve evaluation: 8 levels x 9 rotate/lerp steps through one
// shared multiplier; step divide: one restoring division per Newton step.
// Reset (async, active low) returns to idle, clears the output valid and
// loads tolerance 1, min iterations 10, max iterations 100.
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse core
// Inverts a degree-8 Bezier frequency curve by Newton steps, then evaluates
// the chi curve at the found parameter and scales it to Q16.16.
// ----------------------------------------------------------------------------
module bezier_fit_newton_inverse_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] frequency_i,
  input  logic [31:0] sample_rate_i,
  input  logic [31:0] chi_scale_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] chi_value_o,
  output logic [1:0]  status_o,
  output logic        saturated_o,
  output logic [7:0]  iterations_used_o
);
  import bfn_pkg::*;

  localparam logic [3:0] LastLvl = 4'(CurvePoints - 1);
  localparam logic [3:0] LastJ   = 4'(CurvePoints - 1);
  localparam int         TW      = PW;

  state_e state_q, state_d;

  logic [15:0] tol_q;
  logic [7:0]  min_q, max_q;

  logic [31:0] scale_q;
  logic [31:0] fn_q;
  logic [31:0] t_q;
  pt_t         p_q [CurvePoints];
  pt_t         diff_q;
  logic [3:0]  lvl_q, j_q;
  logic        chi_sel_q;
  logic [7:0]  it_q;
  logic        neg_q;
  logic [QW-1:0] dtmag_q;
  logic [63:0] prod_q;

  logic [31:0] res_val_q;
  logic [1:0]  res_stat_q, stat_q;
  logic        res_sat_q;
  logic [7:0]  res_used_q, used_q;

  logic        out_valid_q;
  logic [31:0] out_val_q;
  logic [1:0]  out_stat_q;
  logic        out_sat_q;
  logic [7:0]  out_used_q;

  div_req_t    div_req;
  div_stat_t   div_stat;
  logic [DW-1:0] div_num, div_den;
  logic [QW-1:0] div_quo;

  // Accepted input transaction and early range check
  logic in_acc, in_bad;
  assign in_acc = in_valid_i && in_ready_o;
  assign in_bad = (sample_rate_i == 32'd0) || (frequency_i >= sample_rate_i);

  // Lerp unit: p0 + (p1 - p0) * t, truncated toward zero
  logic signed [PW:0]  lerp_a;
  logic [PW:0]         lerp_mag;
  logic [PW+32:0]      lerp_prod;
  pt_t                 lerp_step, lerp_res;
  logic                do_lerp;

  assign lerp_a    = {p_q[1][PW-1], p_q[1]} - {p_q[0][PW-1], p_q[0]};
  assign lerp_mag  = lerp_a[PW] ? (~lerp_a + 1'b1) : lerp_a;
  assign lerp_prod = (PW+33)'(lerp_mag) * (PW+33)'(t_q);
  assign lerp_step = pt_t'(lerp_prod[FracBits +: PW]);
  assign lerp_res  = lerp_a[PW] ? (p_q[0] - lerp_step) : (p_q[0] + lerp_step);
  assign do_lerp   = j_q < (4'(CurvePoints) - lvl_q);

  // Step divide setup: (v - fn) / (8 * diff)
  logic signed [DW-1:0] num_s, den_s;
  logic [DW-1:0]        num_u, den_u;
  logic                 den_zero, q_sat, q_int;

  assign num_s    = DW'(p_q[0]) - $signed(DW'(fn_q));
  assign den_s    = DW'(diff_q) <<< 3;
  assign num_u    = num_s[DW-1] ? (~num_s + 1'b1) : num_s;
  assign den_u    = den_s[DW-1] ? (~den_s + 1'b1) : den_s;
  assign den_zero = den_u == '0;
  assign q_sat    = num_u >= {den_u[DW-2:0], 1'b0};
  assign q_int    = num_u >= den_u;

  // Newton update with clamp to [0, 1]
  logic signed [TW-1:0] dt_s, tn_s, tn_c, ad_s;
  logic                 conv, at_limit;
  logic [7:0]           max_eff;

  assign dt_s    = neg_q ? -$signed(TW'(dtmag_q)) : $signed(TW'(dtmag_q));
  assign tn_s    = $signed(TW'(t_q)) - dt_s;
  assign tn_c    = tn_s[TW-1] ? '0 :
                   (tn_s > $signed(TW'(64'd1 << FracBits))) ?
                   $signed(TW'(64'd1 << FracBits)) : tn_s;
  assign ad_s    = (tn_c >= $signed(TW'(t_q))) ? (tn_c - $signed(TW'(t_q)))
                                               : ($signed(TW'(t_q)) - tn_c);
  assign max_eff = (max_q == 8'd0) ? 8'd1 : max_q;
  assign conv    = (it_q >= min_q) && (ad_s < $signed(TW'(tol_q)));
  assign at_limit = (9'(it_q) + 9'd1) == 9'(max_eff);

  // Final scale and saturation
  logic [31:0] v_clamped;
  logic [35:0] prod_sh;
  assign v_clamped = p_q[0][PW-1] ? 32'd0 : p_q[0][31:0];
  assign prod_sh   = prod_q[ChiFrac +: 36];

  bfn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (in_acc) state_d = in_bad ? StDone : StNormDiv;
      StNormDiv:  if (div_stat.done) state_d = StNormChk;
      StNormChk:  state_d = ($signed(PW'(fn_q)) > FreqPts[CurvePoints-1]) ? StDone : StEval;
      StEval: begin
        if (lvl_q == LastLvl && j_q == LastJ) state_d = chi_sel_q ? StScale : StDivSetup;
      end
      StDivSetup: state_d = (den_zero || q_sat) ? StUpdate : StDivRun;
      StDivRun:   if (div_stat.done) state_d = StUpdate;
      StUpdate:   state_d = StEval;
      StScale:    state_d = StSat;
      StSat:      state_d = StDone;
      StDone:     if (!out_valid_q || out_ready_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = state_q == StIdle;
    div_req    = '{start: 1'b0, q_init: 1'b0, steps: 6'd32};
    div_num    = DW'(frequency_i);
    div_den    = DW'(sample_rate_i);
    case (state_q)
      StIdle: begin
        div_req.start = in_acc && !in_bad;
      end
      StDivSetup: begin
        div_req.start  = !den_zero && !q_sat;
        div_req.q_init = q_int;
        div_req.steps  = 6'(FracBits);
        div_num        = q_int ? (num_u - den_u) : num_u;
        div_den        = den_u;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tol_q       <= 16'd1;
      min_q       <= 8'd10;
      max_q       <= 8'd100;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTol:   tol_q <= cfg_data_i;
          CfgMinIt: min_q <= cfg_data_i[7:0];
          CfgMaxIt: max_q <= cfg_data_i[7:0];
          default:  ;
        endcase
      end
      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        scale_q    <= chi_scale_i;
        res_val_q  <= 32'd0;
        res_stat_q <= StatRange;
        res_sat_q  <= 1'b0;
        res_used_q <= 8'd0;
      end
      StNormDiv: begin
        if (div_stat.done) fn_q <= {1'b0, div_quo[31:1]};
      end
      StNormChk: begin
        p_q       <= FreqPts;
        t_q       <= 32'(64'd1 << (FracBits - 1));
        it_q      <= 8'd0;
        lvl_q     <= 4'd1;
        j_q       <= 4'd0;
        chi_sel_q <= 1'b0;
      end
      StEval: begin
        // rotate the point line; live slots take the next lerp
        for (int k = 0; k < CurvePoints - 1; k++) p_q[k] <= p_q[k+1];
        p_q[CurvePoints-1] <= do_lerp ? lerp_res : p_q[0];
        if (lvl_q == LastLvl && j_q == 4'd0) diff_q <= pt_t'(lerp_a);
        if (j_q == LastJ) begin
          j_q   <= 4'd0;
          lvl_q <= lvl_q + 4'd1;
        end else begin
          j_q <= j_q + 4'd1;
        end
      end
      StDivSetup: begin
        neg_q <= num_s[DW-1] ^ den_s[DW-1];
        if (den_zero) dtmag_q <= '0;
        else if (q_sat) dtmag_q <= QW'(64'd2 << FracBits);
      end
      StDivRun: begin
        if (div_stat.done) dtmag_q <= div_quo;
      end
      StUpdate: begin
        t_q   <= tn_c[31:0];
        lvl_q <= 4'd1;
        j_q   <= 4'd0;
        if (conv) begin
          p_q       <= ChiPts;
          chi_sel_q <= 1'b1;
          stat_q    <= StatOk;
          used_q    <= it_q + 8'd1;
        end else if (at_limit) begin
          p_q       <= ChiPts;
          chi_sel_q <= 1'b1;
          stat_q    <= StatNoConv;
          used_q    <= max_eff;
        end else begin
          p_q  <= FreqPts;
          it_q <= it_q + 8'd1;
        end
      end
      StScale: begin
        prod_q <= 64'(v_clamped) * 64'(scale_q);
      end
      StSat: begin
        res_sat_q  <= prod_sh[35:32] != 4'd0;
        res_val_q  <= (prod_sh[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod_sh[31:0];
        res_stat_q <= stat_q;
        res_used_q <= used_q;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_val_q  <= res_val_q;
          out_stat_q <= res_stat_q;
          out_sat_q  <= res_sat_q;
          out_used_q <= res_used_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign chi_value_o       = out_val_q;
  assign status_o          = out_stat_q;
  assign saturated_o       = out_sat_q;
  assign iterations_used_o = out_used_q;

endmodule

// File: sv/bfn_checker.sv
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse: port checker
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
`include "bezier_fit_newton_inverse_core_defines.svh"

module bfn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] chi_value_o,
  input logic [1:0]  status_o,
  input logic        saturated_o,
  input logic [7:0]  iterations_used_o
);
  import bfn_pkg::*;

  // Rejected frequency carries an all-zero result
  `BFN_ASSERT_IMP(a_range_zero, out_valid_o && status_o == StatRange,
                  chi_value_o == 32'd0 && !saturated_o && iterations_used_o == 8'd0,
                  "range result not zero")
  // Saturation pins the value at full scale
  `BFN_ASSERT_IMP(a_sat_max, out_valid_o && saturated_o, chi_value_o == 32'hFFFF_FFFF,
                  "saturated value not full scale")
  // One transaction in flight: busy right after accept
  `BFN_ASSERT_NXT(a_busy, in_valid_i && in_ready_o, !in_ready_o,
                  "ready right after accept")
  // Stalled result holds
  `BFN_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(chi_value_o),
                  "stalled result changed")

endmodule

bind bezier_fit_newton_inverse_core bfn_checker u_bfn_checker (.*);

// File: dv/bezier_fit_newton_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse: transaction checker
// Watches the configuration port and both channels, predicts the result of
// every accepted input transaction and compares it field by field with the
// results in order of arrival.
// ----------------------------------------------------------------------------
module bezier_fit_newton_inverse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] frequency_i,
  input  logic [31:0] sample_rate_i,
  input  logic [31:0] chi_scale_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] chi_value_i,
  input  logic [1:0]  status_i,
  input  logic        saturated_i,
  input  logic [7:0]  iterations_used_i,
  output int          fail_count_o,
  output int          pending_o
);
  import bfn_pkg::*;

  typedef struct packed {
    logic [31:0] chi_value;
    logic [1:0]  status;
    logic        saturated;
    logic [7:0]  iterations;
  } chi_result_t;

  // Mirrored register file
  logic [15:0] tolerance_q;
  logic [7:0]  min_iter_q;
  logic [7:0]  max_iter_q;

  chi_result_t expected_chi_q[$];

  // Product of a point difference and t (Q1.31), truncated toward zero
  function automatic longint scale_by_t(longint a, longint t);
    logic [127:0]    prod;
    longint unsigned mag;
    longint          r;
    mag  = (a < 0) ? -a : a;
    prod = {64'd0, mag} * {64'd0, t};
    r    = longint'((prod >> FracBits) & ((128'd1 << 62) - 1));
    return (a < 0) ? -r : r;
  endfunction

  // Newton step quotient, magnitude saturated at 2.0
  function automatic longint step_quotient(longint num, longint den);
    logic [127:0]    quo;
    longint unsigned un, ud;
    longint          q;
    if (den == 0) return 0;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (un / ud >= 2) begin
      q = longint'(64'd2 << FracBits);
    end else begin
      quo = ({64'd0, un} << FracBits) / {64'd0, ud};
      q   = longint'(quo[63:0]);
    end
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // de Casteljau evaluation; slope gets the last-level difference
  function automatic longint casteljau(input pts_t pts, input longint t,
                                       output longint slope);
    longint p[CurvePoints];
    for (int i = 0; i < CurvePoints; i++) p[i] = longint'(pts[i]);
    slope = 0;
    for (int lvl = 1; lvl < CurvePoints; lvl++) begin
      if (lvl == CurvePoints - 1) slope = p[1] - p[0];
      for (int i = 0; i < CurvePoints - lvl; i++)
        p[i] = p[i] + scale_by_t(p[i+1] - p[i], t);
    end
    return p[0];
  endfunction

  function automatic chi_result_t predict_chi(logic [31:0] freq, logic [31:0] rate,
                                              logic [31:0] scale);
    chi_result_t     res;
    longint unsigned norm32;
    longint          fn, t, tn, v, slope, ad;
    logic [127:0]    prod;
    int              maxit;
    res = '0;
    if (rate == 0 || freq >= rate) begin
      res.status = StatRange;
      return res;
    end
    norm32 = {freq, 32'd0} / {32'd0, rate};
    fn     = longint'(norm32 >> (32 - FracBits));
    if (fn > longint'(FreqPts[CurvePoints-1])) begin
      res.status = StatRange;
      return res;
    end
    maxit = (max_iter_q == 0) ? 1 : int'(max_iter_q);
    t  = 64'sd1 << (FracBits - 1);
    tn = t;
    for (int it = 0; it < maxit; it++) begin
      v  = casteljau(FreqPts, t, slope);
      tn = t - step_quotient(v - fn, (CurvePoints - 1) * slope);
      if (tn < 0) tn = 0;
      else if (tn > (64'sd1 << FracBits)) tn = 64'sd1 << FracBits;
      ad = (tn > t) ? tn - t : t - tn;
      if (it >= min_iter_q && ad < longint'(tolerance_q)) begin
        res.iterations = 8'(it + 1);
        break;
      end
      if (it + 1 == maxit) begin
        res.status     = StatNoConv;
        res.iterations = 8'(maxit);
        break;
      end
      t = tn;
    end
    v = casteljau(ChiPts, tn, slope);
    if (v < 0) v = 0;
    prod = ({64'd0, v} * {96'd0, scale}) >> ChiFrac;
    if (prod > 128'hFFFF_FFFF) begin
      res.chi_value = '1;
      res.saturated = 1'b1;
    end else begin
      res.chi_value = prod[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = expected_chi_q.size();

  // Register mirror, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    chi_result_t want;
    if (!rst_ni) begin
      tolerance_q = 16'd1;
      min_iter_q  = 8'd10;
      max_iter_q  = 8'd100;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTol:   tolerance_q = cfg_data_i;
          CfgMinIt: min_iter_q  = cfg_data_i[7:0];
          CfgMaxIt: max_iter_q  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_chi_q.size() == 0) begin
          report_mismatch("unexpected result", chi_value_i, 0);
        end else begin
          want = expected_chi_q.pop_front();
          if (chi_value_i !== want.chi_value)
            report_mismatch("chi_value", chi_value_i, want.chi_value);
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
          if (saturated_i !== want.saturated)
            report_mismatch("saturated", saturated_i, want.saturated);
          if (iterations_used_i !== want.iterations)
            report_mismatch("iterations_used", iterations_used_i, want.iterations);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_chi_q.push_back(predict_chi(frequency_i, sample_rate_i, chi_scale_i));
    end
  end

endmodule

// File: dv/bezier_fit_newton_inverse_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier fit Newton inverse core testbench
// Drives directed and random frequency lookups through several register
// settings and stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module bezier_fit_newton_inverse_core_tb;
  import bfn_pkg::*;

  localparam int StallLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgTol;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] frequency_i = '0;
  logic [31:0] sample_rate_i = 32'd1;
  logic [31:0] chi_scale_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] chi_value_o;
  logic [1:0]  status_o;
  logic        saturated_o;
  logic [7:0]  iterations_used_o;

  int fail_count;
  int pending;
  int send_idle_pct = 14;
  int recv_idle_pct = 77;
  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  bezier_fit_newton_inverse_core i_dut (.*);

  bezier_fit_newton_inverse_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .frequency_i, .sample_rate_i, .chi_scale_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .chi_value_i(chi_value_o), .status_i(status_o), .saturated_i(saturated_o),
    .iterations_used_i(iterations_used_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_lookup(logic [31:0] freq, logic [31:0] rate, logic [31:0] scale);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    frequency_i   = freq;
    sample_rate_i = rate;
    chi_scale_i   = scale;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Register write once all results are back
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_regs(logic [15:0] tol, logic [7:0] min_it, logic [7:0] max_it);
    write_reg(CfgTol, tol);
    write_reg(CfgMinIt, {8'd0, min_it});
    write_reg(CfgMaxIt, {8'd0, max_it});
  endtask

  // Mostly in-range lookups, some beyond the curve or beyond the rate
  task automatic send_random(int count);
    logic [31:0] rate, freq, scale;
    for (int n = 0; n < count; n++) begin
      rate = $urandom();
      if (rate == 0) rate = 32'd1;
      case ($urandom_range(0, 9))
        0:       freq = $urandom();
        1:       freq = rate + $urandom_range(0, 3);
        default: freq = 32'((64'(rate) * $urandom_range(0, 80111)) / 100000);
      endcase
      case ($urandom_range(0, 7))
        0:       scale = 32'hFFFF_FFFF;
        1:       scale = 32'(1 << $urandom_range(0, 31));
        default: scale = $urandom();
      endcase
      send_lookup(freq, rate, scale);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed lookups at reset settings: field extremes, range edges, saturation
    send_lookup(32'd0, 32'd1, 32'h0001_0000);
    send_lookup(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'd5, 32'd5, 32'h0001_0000);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0001_0000);
    send_lookup(32'd1, 32'hFFFF_FFFF, 32'h8000_0000);
    send_lookup(32'd90, 32'd100, 32'h0001_0000);
    send_lookup(32'd80111, 32'd100000, 32'h0001_0000);
    send_lookup(32'd80112, 32'd100000, 32'h0001_0000);
    send_lookup(32'd16204, 32'd100000, 32'hFFFF_FFFF);
    send_lookup(32'd36886, 32'd100000, 32'd0);
    send_lookup(32'd63124, 32'd100000, 32'hFFFF_FFFF);
    send_lookup(32'd50000, 32'd100000, 32'h0003_0000);
    send_lookup(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_lookup(32'd1, 32'd2, 32'h5555_5555);
    send_lookup(32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'hAAAA_AAAA);

    // Zero tolerance and a two-iteration limit: never converges
    set_regs(16'd0, 8'd1, 8'd2);
    send_random(50);
    // Widest tolerance with minimum 1 and maximum 255
    set_regs(16'hFFFF, 8'd1, 8'd255);
    send_random(70);

    send_idle_pct = 77;
    recv_idle_pct = 14;
    set_regs(16'd200, 8'd3, 8'd20);
    send_random(90);
    // Minimum equals maximum: full-length searches, kept few
    set_regs(16'd1, 8'd255, 8'd255);
    send_random(4);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(16'd50, 8'd2, 8'd30);
    send_random(80);

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bfn_pkg.sv
sv/bfn_div.sv
sv/bezier_fit_newton_inverse_core.sv
sv/bfn_checker.sv
dv/bezier_fit_newton_inverse_checker.sv
dv/bezier_fit_newton_inverse_core_tb.sv
